[hw/rtl/brsu_pkg.sv]
// Package for the bitmap range set / uniform check block.
// Holds word geometry, request kind codes and the result word layout.
// No dependencies.
`default_nettype none

package brsu_pkg;

  // Bitmap word geometry
  localparam int WORD_BITS = 32;
  localparam int BIT_IDX_W = 5;
  localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

  // Request field widths
  localparam int KIND_W  = 2;
  localparam int START_W = 10;
  localparam int COUNT_W = 11;
  localparam int SUM_W   = 12;

  // Request kinds, carried in tuser
  localparam logic [KIND_W-1:0] KIND_RANGE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNIFORM = 2'd2;

  // Result word, answer in bit 0
  typedef struct packed {
    logic out_of_range;
    logic uniform_bit;
    logic answer;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/bitmap_range_set_and_uniform_check.sv]
// Bitmap of NUM_WORDS 32-bit words with range set/clear and prefix checks.
//
// Input channel s_axis: tuser carries the request kind (0 set/clear range,
// 1 check prefix equals value, 2 report uniform prefix value); tdata carries
// start_req, count and value. Output channel m_axis: one 8-bit word per
// request with answer, uniform_bit and out_of_range.
//
// After reset the bitmap is cleared by a sweep over all NUM_WORDS words, one word
// per cycle; s_axis_tready stays low during that sweep.
//
// One request is handled at a time. The bitmap sits in a single memory with
// one write and one registered read port, and one shared mask/compare unit
// handles one word per cycle, reads and writes overlapped. A request that
// touches n words (n at most NUM_WORDS) holds s_axis_tready low while its
// words are read and processed and until its result word moves into the
// output register. Empty, out-of-range and unused requests skip the word pass.
// A check or uniform query stops at the first mismatching word.
//
// The result waits in an output register; while m_axis_tready is low the
// next request may be accepted and processed, but its result is held until
// the output register frees up.
`default_nettype none

module bitmap_range_set_and_uniform_check #(
  parameter int NUM_WORDS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // Request: [9:0] start_req, [20:10] count, [21] value, [23:22] zero
  input  wire logic [23:0] s_axis_tdata,
  // Request kind: [1:0] kind
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // Result: [0] answer, [1] uniform_bit, [2] out_of_range, [7:3] zero
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready
);

  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [31:0] TOTAL_BITS = 32'(NUM_WORDS * brsu_pkg::WORD_BITS);
  localparam int WB = brsu_pkg::WORD_BITS;
  localparam int BW = brsu_pkg::BIT_IDX_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // Request fields
  logic [brsu_pkg::KIND_W-1:0]  in_kind;
  logic [brsu_pkg::START_W-1:0] in_start;
  logic [brsu_pkg::COUNT_W-1:0] in_count;
  logic                         in_value;

  assign in_kind  = s_axis_tuser;
  assign in_start = s_axis_tdata[9:0];
  assign in_count = s_axis_tdata[20:10];
  assign in_value = s_axis_tdata[21];

  // Control and working registers
  logic [1:0]                   state;
  logic [AW-1:0]                clr_ptr;
  logic [brsu_pkg::KIND_W-1:0]  kind;
  logic                         value;
  logic                         want;
  logic [BW-1:0]                beg_bit;
  logic [BW-1:0]                end_bit;
  logic [AW-1:0]                first_w;
  logic [AW-1:0]                last_w;
  logic [AW-1:0]                rd_ptr;
  logic                         rd_on;
  logic                         pend;
  logic [AW-1:0]                wr_ptr;
  brsu_pkg::res_t               res;
  brsu_pkg::res_t               out_res;
  logic                         out_vld;

  // Bitmap storage
  logic [WB-1:0] mem [0:NUM_WORDS-1];
  logic [WB-1:0] mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [WB-1:0] mem_wd;

  // Request decode
  logic [brsu_pkg::SUM_W-1:0]   end_sum;
  logic [brsu_pkg::SUM_W-1:0]   end_m1;
  logic [brsu_pkg::COUNT_W-1:0] cnt_m1;
  logic                         oor_range;
  logic                         oor_prefix;
  logic                         cnt_zero;
  logic                         prefix_kind;
  logic                         run_req;
  brsu_pkg::res_t               res_in;

  assign end_sum    = brsu_pkg::SUM_W'(in_start) + brsu_pkg::SUM_W'(in_count);
  assign end_m1     = end_sum - brsu_pkg::SUM_W'(1);
  assign cnt_m1     = in_count - brsu_pkg::COUNT_W'(1);
  assign oor_range  = 32'(end_sum) > TOTAL_BITS;
  assign oor_prefix = 32'(in_count) > TOTAL_BITS;
  assign cnt_zero   = (in_count == '0);

  assign prefix_kind = in_kind inside {brsu_pkg::KIND_CHECK, brsu_pkg::KIND_UNIFORM};
  assign run_req     = !cnt_zero &&
                       (((in_kind == brsu_pkg::KIND_RANGE) && !oor_range) ||
                        (prefix_kind && !oor_prefix));

  // Result known at accept: flags for ignored and empty requests
  always_comb begin
    res_in              = '0;
    res_in.out_of_range = ((in_kind == brsu_pkg::KIND_RANGE) && !cnt_zero && oor_range) ||
                          (prefix_kind && oor_prefix);
    res_in.answer       = (in_kind == brsu_pkg::KIND_CHECK) && cnt_zero;
  end

  // Shared word unit: mask build, masked compare and masked merge
  logic [WB-1:0] head_m;
  logic [WB-1:0] tail_m;
  logic [WB-1:0] mask;
  logic          want_now;
  logic          match;
  logic [WB-1:0] merged;
  logic          at_last;
  logic          miss;
  logic          fin_go;

  assign head_m   = brsu_pkg::FULL_WORD << beg_bit;
  assign tail_m   = brsu_pkg::FULL_WORD >> BW'(BW'(0) - end_bit);
  assign mask     = ((wr_ptr == first_w) ? head_m : brsu_pkg::FULL_WORD) &
                    ((wr_ptr == last_w)  ? tail_m : brsu_pkg::FULL_WORD);
  assign want_now = (kind == brsu_pkg::KIND_UNIFORM && wr_ptr == '0) ? mem_q[0] : want;
  assign match    = ((mem_q ^ {WB{want_now}}) & mask) == '0;
  assign merged   = value ? (mem_q | mask) : (mem_q & ~mask);
  assign at_last  = (wr_ptr == last_w);

  // Early stop of a prefix check, and handoff to the output register
  assign miss   = pend && (kind != brsu_pkg::KIND_RANGE) && !match;
  assign fin_go = (state == ST_FIN) && (!out_vld || m_axis_tready);

  // Memory write select: clearing sweep or range update
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_ptr;
    mem_wd = merged;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_ptr;
      mem_wd = '0;
    end else if (state == ST_RUN && pend && kind == brsu_pkg::KIND_RANGE) begin
      mem_we = 1'b1;
    end
  end

  // Single-port-pair memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[rd_ptr];
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {5'b0, out_res};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_ptr <= '0;
      rd_on   <= 1'b0;
      pend    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      // Output register: load a finished result, drop it once taken
      if (fin_go) begin
        out_res <= res;
        out_vld <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_ptr <= clr_ptr + AW'(1);
          if (clr_ptr == AW'(NUM_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            kind  <= in_kind;
            value <= in_value;
            want  <= in_value;
            res   <= res_in;
            rd_on <= run_req;
            pend  <= 1'b0;
            state <= run_req ? ST_RUN : ST_FIN;
            case (in_kind)
              brsu_pkg::KIND_RANGE: begin
                beg_bit <= in_start[BW-1:0];
                end_bit <= end_sum[BW-1:0];
                first_w <= AW'(in_start[brsu_pkg::START_W-1:BW]);
                rd_ptr  <= AW'(in_start[brsu_pkg::START_W-1:BW]);
                last_w  <= AW'(end_m1[brsu_pkg::SUM_W-1:BW]);
              end
              brsu_pkg::KIND_CHECK, brsu_pkg::KIND_UNIFORM: begin
                beg_bit <= '0;
                end_bit <= in_count[BW-1:0];
                first_w <= '0;
                rd_ptr  <= '0;
                last_w  <= AW'(cnt_m1[brsu_pkg::COUNT_W-1:BW]);
              end
              default: begin
                beg_bit <= '0;
                end_bit <= '0;
              end
            endcase
          end
        end
        ST_RUN: begin
          // Read side: issue one word per cycle up to the last word
          pend  <= rd_on && !miss;
          rd_on <= rd_on && !miss && (rd_ptr != last_w);
          if (rd_on) begin
            wr_ptr <= rd_ptr;
            if (rd_ptr != last_w) begin
              rd_ptr <= rd_ptr + AW'(1);
            end
          end
          // Process side: word read in the previous cycle
          if (pend) begin
            want <= want_now;
            if (kind != brsu_pkg::KIND_RANGE && match && at_last) begin
              res.answer      <= 1'b1;
              res.uniform_bit <= (kind == brsu_pkg::KIND_UNIFORM) & want_now;
            end
            if (miss || at_last) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          pend <= 1'b0;
          if (fin_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/brsu_checker.sv]
// Port-level checker for the bitmap range set / uniform check block.
// Depends on bitmap_range_set_and_uniform_check; attached by bind below.
`default_nettype none

module brsu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready
);

  // Result word held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // One request at a time: not ready right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accepting a request");

  // Clearing sweep follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("block ready or valid right after reset");

  // Flag consistency: out of range clears answer, uniform bit needs answer
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'b0) &&
      !(m_axis_tdata[1] && !m_axis_tdata[0]) &&
      !(m_axis_tdata[2] && (m_axis_tdata[1] || m_axis_tdata[0])))
    else $error("inconsistent result flags");

endmodule

bind bitmap_range_set_and_uniform_check brsu_checker u_brsu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

[test/bitmap_range_set_and_uniform_check_test.sv]
// Self-checking testbench for bitmap_range_set_and_uniform_check.
// Drives range, check, uniform and unused-kind requests and checks every result word
// against a bit-level model of the bitmap. Depends on brsu_pkg and the DUT.

module bitmap_range_set_and_uniform_check_test;

  localparam int NUM_WORDS     = 32;
  localparam int TOTAL_BITS    = NUM_WORDS * brsu_pkg::WORD_BITS;
  localparam int MAX_COUNT     = 2047;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 2 * NUM_WORDS + 40;

  // kind code the block does not use
  localparam logic [brsu_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;

  // Model of the bitmap and results still owed by the DUT
  logic [TOTAL_BITS-1:0] bitmap_model = '0;
  brsu_pkg::res_t expected_results[$];
  int   error_count = 0;
  bit   src_no_gaps = 1'b0;
  bit   sink_no_stalls = 1'b0;

  bitmap_range_set_and_uniform_check #(
    .NUM_WORDS(NUM_WORDS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always #5 clk = ~clk;

  // True when bits [len-1:0] of the model all equal bit_val
  function automatic bit prefix_matches(int len, logic bit_val);
    for (int i = 0; i < len; i++) begin
      if (bitmap_model[i] != bit_val) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one request to the model and returns the result word it owes
  function automatic brsu_pkg::res_t predict_bitmap_result(logic [1:0] kind, logic [9:0] start,
                                                           logic [10:0] count, logic bit_val);
    brsu_pkg::res_t r;
    logic lead;
    r = '0;
    case (kind)
      brsu_pkg::KIND_RANGE: begin
        if (count != 0) begin
          if (int'(start) + int'(count) > TOTAL_BITS) begin
            r.out_of_range = 1'b1;
          end else begin
            for (int i = int'(start); i < int'(start) + int'(count); i++)
              bitmap_model[i] = bit_val;
          end
        end
      end
      brsu_pkg::KIND_CHECK: begin
        if (int'(count) > TOTAL_BITS) r.out_of_range = 1'b1;
        else r.answer = prefix_matches(int'(count), bit_val);
      end
      brsu_pkg::KIND_UNIFORM: begin
        lead = bitmap_model[0];
        if (int'(count) > TOTAL_BITS) begin
          r.out_of_range = 1'b1;
        end else if (count != 0 && prefix_matches(int'(count), lead)) begin
          r.answer      = 1'b1;
          r.uniform_bit = lead;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one request word; tvalid stays high if the next word follows at once
  task automatic send_request(input logic [1:0] kind, input logic [9:0] start,
                              input logic [10:0] count, input logic bit_val);
    int gap;
    gap = src_no_gaps ? 0 : int'($urandom_range(0, 19));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, bit_val, count, start};
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(predict_bitmap_result(kind, start, count, bit_val));
  endtask

  // Hold off the sender until the DUT has delivered every owed result
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Count biased toward word edges, tiny sizes and the upper bound
  function automatic logic [10:0] pick_count(int limit);
    int c;
    case ($urandom_range(0, 5))
      0: c = int'($urandom_range(0, 40));
      1: c = 32 * int'($urandom_range(0, NUM_WORDS)) + int'($urandom_range(0, 2)) - 1;
      2: c = limit;
      default: c = int'($urandom_range(0, limit));
    endcase
    if (c < 0) c = 0;
    if (c > limit) c = limit;
    return c[10:0];
  endfunction

  // Queries on the freshly cleared bitmap
  task automatic test_cleared_bitmap();
    send_request(brsu_pkg::KIND_CHECK, 10'd0, 11'd1024, 1'b0);
    send_request(brsu_pkg::KIND_CHECK, 10'd0, 11'd1024, 1'b1);
    send_request(brsu_pkg::KIND_UNIFORM, 10'd0, 11'd1024, 1'b0);
    send_request(brsu_pkg::KIND_UNIFORM, 10'd0, 11'd0, 1'b1);   // empty uniform query
    send_request(brsu_pkg::KIND_CHECK, 10'd0, 11'd0, 1'b1);     // empty check
  endtask

  // Field extremes, boundary masks and every ignored case
  task automatic test_directed_edges();
    send_request(brsu_pkg::KIND_RANGE, 10'd0, 11'd1024, 1'b1);      // whole bitmap
    send_request(brsu_pkg::KIND_UNIFORM, 10'h3FF, 11'd1024, 1'b0);
    send_request(brsu_pkg::KIND_RANGE, 10'd1023, 11'd1, 1'b0);      // last bit only
    send_request(brsu_pkg::KIND_CHECK, 10'd0, 11'd1023, 1'b1);
    send_request(brsu_pkg::KIND_CHECK, 10'd0, 11'd1024, 1'b1);
    send_request(brsu_pkg::KIND_RANGE, 10'd5, 11'd27, 1'b0);        // inside one word
    send_request(brsu_pkg::KIND_RANGE, 10'd31, 11'd34, 1'b0);       // spans three words
    send_request(brsu_pkg::KIND_CHECK, 10'd0, 11'd5, 1'b1);
    send_request(brsu_pkg::KIND_UNIFORM, 10'd0, 11'd6, 1'b0);
    send_request(brsu_pkg::KIND_RANGE, 10'd1000, 11'd24, 1'b0);     // ends on the last bit
    send_request(brsu_pkg::KIND_RANGE, 10'd0, 11'd0, 1'b1);         // empty write
    send_request(brsu_pkg::KIND_RANGE, 10'd1023, 11'd2, 1'b1);      // range past the end
    send_request(brsu_pkg::KIND_RANGE, 10'h3FF, 11'h7FF, 1'b1);
    send_request(brsu_pkg::KIND_CHECK, 10'd0, 11'd1025, 1'b0);      // prefix past the end
    send_request(brsu_pkg::KIND_UNIFORM, 10'h3FF, 11'h7FF, 1'b1);
    send_request(KIND_UNUSED, 10'h3FF, 11'h7FF, 1'b1);              // unused kind
    send_request(KIND_UNUSED, 10'd0, 11'd0, 1'b0);
    send_request(brsu_pkg::KIND_CHECK, 10'd0, 11'd1024, 1'b0);
  endtask

  // Prefix write followed by queries around its length
  task automatic test_prefix_sequences(int n);
    logic [10:0] len;
    logic        bit_val;
    for (int s = 0; s < n; s++) begin
      len     = pick_count(TOTAL_BITS);
      bit_val = 1'($urandom_range(0, 1));
      send_request(brsu_pkg::KIND_RANGE, 10'd0, len, bit_val);
      if ($urandom_range(0, 3) == 0)
        send_request(brsu_pkg::KIND_RANGE, 10'($urandom_range(0, TOTAL_BITS - 1)), 11'd1,
                     ~bit_val);
      send_request(brsu_pkg::KIND_CHECK, 10'($urandom), 11'($urandom_range(0, len)),
                   bit_val);
      send_request(brsu_pkg::KIND_UNIFORM, 10'($urandom), 11'($urandom_range(0, len)),
                   1'($urandom));
      send_request($urandom_range(0, 1) ? brsu_pkg::KIND_CHECK : brsu_pkg::KIND_UNIFORM,
                   10'($urandom), (len < TOTAL_BITS) ? len + 11'd1 : len, 1'($urandom));
    end
  endtask

  // Mixed traffic with a share of rejected and unused requests
  task automatic test_random_mix(int n);
    int          sel;
    logic [9:0]  start;
    logic [10:0] count;
    for (int i = 0; i < n; i++) begin
      sel = int'($urandom_range(0, 99));
      if (sel < 45) begin
        start = 10'($urandom_range(0, TOTAL_BITS - 1));
        send_request(brsu_pkg::KIND_RANGE, start, pick_count(TOTAL_BITS - int'(start)),
                     1'($urandom));
      end else if (sel < 65) begin
        send_request(brsu_pkg::KIND_CHECK, 10'($urandom), pick_count(TOTAL_BITS),
                     1'($urandom));
      end else if (sel < 85) begin
        send_request(brsu_pkg::KIND_UNIFORM, 10'($urandom), pick_count(TOTAL_BITS),
                     1'($urandom));
      end else if (sel < 92) begin
        start = 10'($urandom_range(1, TOTAL_BITS - 1));
        count = 11'($urandom_range(TOTAL_BITS - int'(start) + 1, MAX_COUNT));
        send_request(brsu_pkg::KIND_RANGE, start, count, 1'($urandom));
      end else if (sel < 96) begin
        send_request($urandom_range(0, 1) ? brsu_pkg::KIND_CHECK : brsu_pkg::KIND_UNIFORM,
                     10'($urandom), 11'($urandom_range(TOTAL_BITS + 1, MAX_COUNT)),
                     1'($urandom));
      end else begin
        send_request(KIND_UNUSED, 10'($urandom), 11'($urandom), 1'($urandom));
      end
    end
  endtask

  // Result sink: random stall before each word, none in burst phases
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = sink_no_stalls ? 0 : int'($urandom_range(0, 19));
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    brsu_pkg::res_t got;
    brsu_pkg::res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = brsu_pkg::res_t'(m_axis_tdata[2:0]);
      if (expected_results.size() == 0) begin
        $error("unexpected result word 0x%02h", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.answer != want.answer) begin
          $error("answer: expected %0d, got %0d", want.answer, got.answer);
          error_count++;
        end
        if (got.uniform_bit != want.uniform_bit) begin
          $error("uniform_bit: expected %0d, got %0d", want.uniform_bit, got.uniform_bit);
          error_count++;
        end
        if (got.out_of_range != want.out_of_range) begin
          $error("out_of_range: expected %0d, got %0d", want.out_of_range,
                 got.out_of_range);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("bitmap_range_set_and_uniform_check_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_cleared_bitmap();
    test_directed_edges();
    wait_for_results();

    // back-to-back on both sides
    src_no_gaps    = 1'b1;
    sink_no_stalls = 1'b1;
    test_prefix_sequences(15);
    test_random_mix(80);
    wait_for_results();

    src_no_gaps    = 1'b0;
    sink_no_stalls = 1'b0;
    test_prefix_sequences(25);
    test_random_mix(140);
    wait_for_results();

    // fast sender into a slow sink, then the reverse
    src_no_gaps = 1'b1;
    test_random_mix(80);
    test_prefix_sequences(10);
    src_no_gaps    = 1'b0;
    sink_no_stalls = 1'b1;
    test_random_mix(80);
    test_prefix_sequences(10);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("bitmap_range_set_and_uniform_check_test: PASS");
    else
      $display("bitmap_range_set_and_uniform_check_test: FAIL");
    $finish;
  end

endmodule
